// File: design/rmh_pkg.sv
package rmh_pkg;

  localparam int CountBits = 11;

  // heap datapath commands
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_RD,
    CMD_WR,
    CMD_SWAP
  } rmh_cmd_e;

endpackage

// File: design/running_median_two_heaps_top.sv
// Running median over a stream of signed samples, kept in a max-heap (lower
// half) and a min-heap (upper half), each in its own single-port memory.
// Each request yields one result: twice the median, the stored count and a
// drop flag once CAPACITY samples are held. One sample at a time is in work:
// the next is taken only after the result of the last has been accepted.
module running_median_two_heaps_top import rmh_pkg::*; #(
  parameter int CAPACITY = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  input  logic [SAMPLE_BITS-1:0]  s_axis_tdata_i,   // sample
  output logic                    m_axis_tvalid_o,
  input  logic                    m_axis_tready_i,
  // median_doubled, stored_count, dropped
  output logic [((SAMPLE_BITS+CountBits+2+7)/8)*8-1:0] m_axis_tdata_o
);

  localparam int Depth = (CAPACITY + 1) / 2;
  localparam int SW = $clog2(Depth + 1);
  localparam int OutBits = ((SAMPLE_BITS + CountBits + 2 + 7) / 8) * 8;

  logic lo_push, lo_pop, hi_push, hi_pop, lo_busy, hi_busy;
  logic signed [SAMPLE_BITS-1:0] lo_val, hi_val, lo_top, hi_top, lo_popv, hi_popv;
  logic [SW-1:0] lo_size, hi_size;
  logic signed [SAMPLE_BITS:0] median;
  logic [CountBits-1:0] count;
  logic dropped;

  rmh_heap #(.Depth(Depth), .SampleBits(SAMPLE_BITS), .IsMax(1'b1)) u_lo (
    .clk_i, .rst_ni, .push_i(lo_push), .pop_i(lo_pop), .value_i(lo_val),
    .busy_o(lo_busy), .top_o(lo_top), .popped_o(lo_popv), .size_o(lo_size));

  rmh_heap #(.Depth(Depth), .SampleBits(SAMPLE_BITS), .IsMax(1'b0)) u_hi (
    .clk_i, .rst_ni, .push_i(hi_push), .pop_i(hi_pop), .value_i(hi_val),
    .busy_o(hi_busy), .top_o(hi_top), .popped_o(hi_popv), .size_o(hi_size));

  rmh_ctrl #(.Capacity(CAPACITY), .SampleBits(SAMPLE_BITS), .SW(SW)) u_ctrl (
    .clk_i, .rst_ni,
    .in_fire_i(s_axis_tvalid_i && s_axis_tready_o),
    .sample_i(s_axis_tdata_i),
    .out_fire_i(m_axis_tvalid_o && m_axis_tready_i),
    .lo_busy_i(lo_busy), .hi_busy_i(hi_busy), .lo_top_i(lo_top), .hi_top_i(hi_top),
    .lo_pop_i(lo_popv), .hi_pop_i(hi_popv), .lo_size_i(lo_size), .hi_size_i(hi_size),
    .lo_push_o(lo_push), .lo_pop_o(lo_pop), .hi_push_o(hi_push), .hi_pop_o(hi_pop),
    .lo_val_o(lo_val), .hi_val_o(hi_val),
    .in_ready_o(s_axis_tready_o), .out_valid_o(m_axis_tvalid_o),
    .median_o(median), .count_o(count), .dropped_o(dropped));

  assign m_axis_tdata_o = OutBits'({dropped, count, median});

endmodule

// File: design/rmh_heap.sv
// One heap held in a single-port memory with a registered read and a tiny
// sift engine. The top entry is mirrored in a register for the median.
module rmh_heap import rmh_pkg::*; #(
  parameter int Depth = 512,
  parameter int SampleBits = 16,
  parameter bit IsMax = 1'b1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  logic                          pop_i,
  input  logic signed [SampleBits-1:0]  value_i,
  output logic                          busy_o,
  output logic signed [SampleBits-1:0]  top_o,
  output logic signed [SampleBits-1:0]  popped_o,
  output logic [$clog2(Depth+1)-1:0]    size_o
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int SW = $clog2(Depth+1);

  localparam logic [3:0] S_IDLE = 4'd0, S_UP_RD = 4'd1, S_UP_CMP = 4'd2,
                         S_DN_RDL = 4'd3, S_DN_RDR = 4'd4, S_DN_CMP = 4'd5,
                         S_DN_WR = 4'd6, S_DN_WAIT = 4'd7, S_DN_WAITR = 4'd8;

  logic signed [SampleBits-1:0] mem [Depth];
  logic signed [SampleBits-1:0] rd_q;
  logic [3:0] st_q, st_d;
  logic [SW-1:0] size_q, size_d;
  logic [SW:0] idx_q, idx_d;
  logic signed [SampleBits-1:0] val_q, val_d, top_q, top_d, pop_q, pop_d, lc_q, lc_d;
  logic we, re;
  logic [AW-1:0] waddr, raddr;
  logic signed [SampleBits-1:0] wdata;
  logic [SW:0] par, lch, rch;

  function automatic logic outranks(input logic signed [SampleBits-1:0] a,
                                    input logic signed [SampleBits-1:0] b);
    outranks = IsMax ? (a > b) : (a < b);
  endfunction

  assign par = (idx_q - 1'b1) >> 1;
  assign lch = {idx_q[SW-1:0], 1'b1};
  assign rch = lch + 1'b1;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rd_q <= mem[raddr];
  end

  // sift carries val_q as a hole; the hole is written when it settles
  always_comb begin
    st_d = st_q; size_d = size_q; idx_d = idx_q; val_d = val_q; top_d = top_q;
    pop_d = pop_q; lc_d = lc_q;
    we = 1'b0; re = 1'b0; waddr = '0; raddr = '0; wdata = val_q;
    case (st_q)
      S_IDLE: begin
        if (push_i) begin
          val_d = value_i; idx_d = {1'b0, size_q}; size_d = size_q + 1'b1;
          st_d = S_UP_RD;
        end else if (pop_i) begin
          pop_d = top_q; size_d = size_q - 1'b1; idx_d = '0;
          re = 1'b1; raddr = AW'(size_q - 1'b1);
          st_d = S_DN_WAIT;
        end
      end
      S_UP_RD: begin
        if (idx_q == '0) begin
          we = 1'b1; waddr = '0; top_d = val_q; st_d = S_IDLE;
        end else begin
          re = 1'b1; raddr = AW'(par); st_d = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (outranks(val_q, rd_q)) begin
          we = 1'b1; waddr = AW'(idx_q); wdata = rd_q; idx_d = par; st_d = S_UP_RD;
        end else begin
          we = 1'b1; waddr = AW'(idx_q); st_d = S_IDLE;
        end
      end
      S_DN_WAIT: begin
        val_d = rd_q; st_d = S_DN_RDL;
      end
      S_DN_RDL: begin
        if (lch >= {1'b0, size_q}) begin
          st_d = S_DN_WR;
        end else begin
          re = 1'b1; raddr = AW'(lch); st_d = S_DN_WAITR;
        end
      end
      S_DN_WAITR: begin
        lc_d = rd_q;
        if (rch >= {1'b0, size_q}) st_d = S_DN_CMP;
        else begin
          re = 1'b1; raddr = AW'(rch); st_d = S_DN_RDR;
        end
      end
      S_DN_RDR: begin
        // pick the better child; ties keep the left one
        if (outranks(rd_q, lc_q)) begin
          if (outranks(rd_q, val_q)) begin
            we = 1'b1; waddr = AW'(idx_q); wdata = rd_q;
            if (idx_q == '0) top_d = rd_q;
            idx_d = rch; st_d = S_DN_RDL;
          end else st_d = S_DN_WR;
        end else st_d = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (outranks(lc_q, val_q)) begin
          we = 1'b1; waddr = AW'(idx_q); wdata = lc_q;
          if (idx_q == '0) top_d = lc_q;
          idx_d = lch; st_d = S_DN_RDL;
        end else st_d = S_DN_WR;
      end
      S_DN_WR: begin
        we = 1'b1; waddr = AW'(idx_q);
        if (idx_q == '0) top_d = val_q;
        st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; size_q <= '0;
    end else begin
      st_q <= st_d; size_q <= size_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d; val_q <= val_d; top_q <= top_d; pop_q <= pop_d; lc_q <= lc_d;
  end

  assign busy_o = (st_q != S_IDLE);
  assign top_o = top_q;
  assign popped_o = pop_q;
  assign size_o = size_q;

endmodule

// File: design/rmh_ctrl.sv
// Sequencer: rebalance if needed, place the sample (unless the store is full), then present the result.
module rmh_ctrl import rmh_pkg::*; #(
  parameter int Capacity = 1024,
  parameter int SampleBits = 16,
  parameter int SW = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_fire_i,
  input  logic signed [SampleBits-1:0]  sample_i,
  input  logic                          out_fire_i,
  input  logic                          lo_busy_i,
  input  logic                          hi_busy_i,
  input  logic signed [SampleBits-1:0]  lo_top_i,
  input  logic signed [SampleBits-1:0]  hi_top_i,
  input  logic signed [SampleBits-1:0]  lo_pop_i,
  input  logic signed [SampleBits-1:0]  hi_pop_i,
  input  logic [SW-1:0]                 lo_size_i,
  input  logic [SW-1:0]                 hi_size_i,
  output logic                          lo_push_o,
  output logic                          lo_pop_o,
  output logic                          hi_push_o,
  output logic                          hi_pop_o,
  output logic signed [SampleBits-1:0]  lo_val_o,
  output logic signed [SampleBits-1:0]  hi_val_o,
  output logic                          in_ready_o,
  output logic                          out_valid_o,
  output logic signed [SampleBits:0]    median_o,
  output logic [CountBits-1:0]          count_o,
  output logic                          dropped_o
);

  localparam logic [2:0] C_IDLE = 3'd0, C_POP = 3'd1, C_MOVE = 3'd2, C_PUSH = 3'd3,
                         C_WAIT = 3'd4, C_OUT = 3'd5;
  localparam int NW = SW + 1;

  logic [2:0] st_q, st_d;
  logic signed [SampleBits-1:0] x_q;
  logic tolo_q, fromlo_q, drop_q;
  logic [NW-1:0] total;
  logic idle_heaps;

  assign idle_heaps = !lo_busy_i && !hi_busy_i;
  assign total = NW'(lo_size_i) + NW'(hi_size_i);

  always_comb begin
    st_d = st_q;
    lo_push_o = 1'b0; lo_pop_o = 1'b0; hi_push_o = 1'b0; hi_pop_o = 1'b0;
    lo_val_o = x_q; hi_val_o = x_q;
    case (st_q)
      C_IDLE: if (in_fire_i) st_d = C_POP;
      C_POP: begin
        if (drop_q) st_d = C_WAIT;
        else if (lo_size_i == hi_size_i) st_d = C_PUSH;
        else if (lo_size_i > hi_size_i) begin
          if (x_q >= lo_top_i) st_d = C_PUSH;
          else begin lo_pop_o = 1'b1; st_d = C_MOVE; end
        end else begin
          if (x_q <= hi_top_i) st_d = C_PUSH;
          else begin hi_pop_o = 1'b1; st_d = C_MOVE; end
        end
      end
      C_MOVE: if (idle_heaps) begin
        if (fromlo_q) begin hi_push_o = 1'b1; hi_val_o = lo_pop_i; end
        else begin lo_push_o = 1'b1; lo_val_o = hi_pop_i; end
        st_d = C_PUSH;
      end
      C_PUSH: if (idle_heaps) begin
        if (tolo_q) lo_push_o = 1'b1; else hi_push_o = 1'b1;
        st_d = C_WAIT;
      end
      C_WAIT: if (idle_heaps) st_d = C_OUT;
      C_OUT: if (out_fire_i) st_d = C_IDLE;
      default: st_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= C_IDLE;
    else st_q <= st_d;
  end

  // decide destination once sizes are known (C_POP)
  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      x_q <= sample_i;
      drop_q <= (32'(total) >= Capacity);
    end
    if (st_q == C_POP) begin
      fromlo_q <= (lo_size_i > hi_size_i);
      if (lo_size_i == hi_size_i)
        tolo_q <= (lo_size_i == '0) || (x_q < lo_top_i);
      else if (lo_size_i > hi_size_i) tolo_q <= (x_q < lo_top_i);
      else tolo_q <= !(x_q > hi_top_i);
    end
  end

  always_comb begin
    if (lo_size_i == hi_size_i) median_o = (SampleBits+1)'(lo_top_i) + (SampleBits+1)'(hi_top_i);
    else if (lo_size_i > hi_size_i) median_o = {lo_top_i, 1'b0};
    else median_o = {hi_top_i, 1'b0};
  end

  assign count_o = CountBits'(total);
  assign dropped_o = drop_q;
  assign in_ready_o = (st_q == C_IDLE);
  assign out_valid_o = (st_q == C_OUT);

`ifndef SYNTHESIS
  a_no_push_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lo_push_o |-> !lo_busy_i) else $error("push to busy lower heap");
  a_out_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> idle_heaps) else $error("result while heap busy");
  a_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (lo_size_i <= hi_size_i + 1'b1 && hi_size_i <= lo_size_i + 1'b1))
    else $error("heaps unbalanced");
`endif

endmodule

// File: verif/running_median_two_heaps_checker.sv
module running_median_two_heaps_checker import rmh_pkg::*; #(
  parameter int CAPACITY = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid_i,
  input  logic                    s_axis_tready_i,
  input  logic [SAMPLE_BITS-1:0]  s_axis_tdata_i,   // sample
  input  logic                    m_axis_tvalid_i,
  input  logic                    m_axis_tready_i,
  input  logic [31:0]             m_axis_tdata_i,   // median_doubled, stored_count, dropped
  output int                      error_count_o,
  output int                      pending_o,
  output int                      result_count_o,
  output int                      drop_count_o
);

  typedef struct packed {
    logic                   dropped;
    logic [CountBits-1:0]   stored_count;
    logic [SAMPLE_BITS:0]   median_doubled;
  } median_result_t;

  // samples held, kept in ascending order
  int             sorted_samples[$];
  median_result_t expected_medians[$];

  function automatic median_result_t predict_median(logic signed [SAMPLE_BITS-1:0] smp);
    median_result_t r;
    int n;
    int pos;
    int twice;
    r.dropped = 1'b0;
    n = sorted_samples.size();
    if (n >= CAPACITY) begin
      r.dropped = 1'b1;
    end else begin
      pos = 0;
      while (pos < n && sorted_samples[pos] <= int'(smp)) pos++;
      sorted_samples.insert(pos, int'(smp));
      n++;
    end
    if (n[0]) twice = 2 * sorted_samples[(n - 1) / 2];
    else twice = sorted_samples[n / 2 - 1] + sorted_samples[n / 2];
    r.median_doubled = twice[SAMPLE_BITS:0];
    r.stored_count = n[CountBits-1:0];
    return r;
  endfunction

  assign pending_o = expected_medians.size();

  always @(posedge clk_i or negedge rst_ni) begin
    median_result_t got;
    median_result_t want;
    if (!rst_ni) begin
      error_count_o  <= 0;
      result_count_o <= 0;
      drop_count_o   <= 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        expected_medians.push_back(predict_median(s_axis_tdata_i));
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = m_axis_tdata_i[$bits(median_result_t)-1:0];
        result_count_o <= result_count_o + 1;
        if (got.dropped) drop_count_o <= drop_count_o + 1;
        if (expected_medians.size() == 0) begin
          if (error_count_o < 10) $display("ERROR: result %h with no request pending", got);
          error_count_o <= error_count_o + 1;
        end else begin
          want = expected_medians.pop_front();
          if (got !== want) begin
            if (error_count_o < 10)
              $display("ERROR: median %h/%h count %0d/%0d dropped %b/%b (expected/actual)",
                       want.median_doubled, got.median_doubled, want.stored_count,
                       got.stored_count, want.dropped, got.dropped);
            error_count_o <= error_count_o + 1;
          end
        end
      end
    end
  end
endmodule

// File: verif/running_median_two_heaps_top_test.sv
module running_median_two_heaps_top_test;
  localparam int Capacity = 1024;
  localparam int SampleBits = 16;
  localparam int NumRandom = 1030;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  logic [SampleBits-1:0]  s_axis_tdata_i;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i;
  logic [31:0]            m_axis_tdata_o;
  logic                   quiet;
  int                     error_count;
  int                     pending;
  int                     result_count;
  int                     drop_count;

  running_median_two_heaps_top #(.CAPACITY(Capacity), .SAMPLE_BITS(SampleBits)) u_dut (
    .clk_i, .rst_ni, .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o
  );

  running_median_two_heaps_checker #(.CAPACITY(Capacity), .SAMPLE_BITS(SampleBits)) u_check (
    .clk_i, .rst_ni, .s_axis_tvalid_i, .s_axis_tready_i(s_axis_tready_o), .s_axis_tdata_i,
    .m_axis_tvalid_i(m_axis_tvalid_o), .m_axis_tready_i, .m_axis_tdata_i(m_axis_tdata_o),
    .error_count_o(error_count), .pending_o(pending),
    .result_count_o(result_count), .drop_count_o(drop_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  initial m_axis_tready_i = 1'b0;
  always @(negedge clk_i) m_axis_tready_i <= quiet || ($urandom_range(99) >= 15);

  task automatic send_sample(logic [SampleBits-1:0] smp);
    @(negedge clk_i);
    if (!quiet && $urandom_range(99) < 15) begin
      s_axis_tvalid_i = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = smp;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  initial begin
    logic [SampleBits-1:0] directed[$];
    int mode;
    directed = '{16'h0005, 16'h0005, 16'h0005, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff,
                 16'h0000, 16'hffff, 16'h0001, 16'h0001, 16'hffff, 16'h7fff, 16'h7fff,
                 16'h8000, 16'h0000, 16'h0003, 16'h0003, 16'h0002, 16'h0004};
    quiet = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    foreach (directed[k]) send_sample(directed[k]);
    for (int k = 0; k < NumRandom; k++) begin
      quiet = (k >= 300 && k < 500);
      mode = $urandom_range(9);
      // mix wide values, a narrow band that forces ties, and the extremes
      if (mode < 5) send_sample(16'($urandom()));
      else if (mode < 9) send_sample(16'($signed($urandom_range(8)) - 4));
      else send_sample($urandom_range(1) ? 16'h7fff : 16'h8000);
    end
    quiet = 1'b0;
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("Sent %0d samples, checked %0d results, %0d of them with a full store.",
             directed.size() + NumRandom, result_count, drop_count);
    if (error_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule

// File: files.f
design/rmh_pkg.sv
design/rmh_heap.sv
design/rmh_ctrl.sv
design/running_median_two_heaps_top.sv
verif/running_median_two_heaps_checker.sv
verif/running_median_two_heaps_top_test.sv
